// File: rtl/core/yjk_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// yjk_pkg
// Types and constants shared by the YJK group encoder.
// ---------------------------------------------------------------------------
package yjk_pkg;

  localparam int NumPix  = 4;
  localparam int NumY    = 32;
  localparam int ErrW    = 10;
  localparam int KeyW    = ErrW + 1;
  localparam int SumW    = 27;
  localparam logic [SumW-1:0] StartErr = SumW'(255 * 255 * 255);

  typedef struct packed {
    logic [7:0] red0;
    logic [7:0] green0;
    logic [7:0] blue0;
    logic [7:0] red1;
    logic [7:0] green1;
    logic [7:0] blue1;
    logic [7:0] red2;
    logic [7:0] green2;
    logic [7:0] blue2;
    logic [7:0] red3;
    logic [7:0] green3;
    logic [7:0] blue3;
  } pixels_t;

  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
  } result_t;

endpackage

// File: rtl/core/yjk_lane.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// yjk_lane
// Best luma of one pixel under one chroma pair; all 32 Y in parallel,
// three register stages (errors, partial minimum, final minimum).
// ---------------------------------------------------------------------------
module yjk_lane import yjk_pkg::*; (
  input  logic              clk,
  input  logic [7:0]        red,
  input  logic [7:0]        green,
  input  logic [7:0]        blue,
  input  logic signed [5:0] chroma_j,
  input  logic signed [5:0] chroma_k,
  input  logic              clamp,
  output logic [KeyW-1:0]   key,
  output logic [4:0]        luma
);

  logic [KeyW-1:0] cand_key [NumY];
  logic [KeyW-1:0] cand_key_next [NumY];
  logic [KeyW-1:0] grp_key [4];
  logic [4:0]      grp_y [4];
  logic [KeyW-1:0] grp_key_next [4];
  logic [4:0]      grp_y_next [4];
  logic [KeyW-1:0] key_next;
  logic [4:0]      luma_next;

  function automatic logic [4:0] sat5(input logic signed [7:0] v);
    logic [4:0] c;
    if (v < 0) c = 5'd0;
    else if (v > 8'sd31) c = 5'd31;
    else c = v[4:0];
    return c;
  endfunction

  function automatic logic [8:0] absd(input logic [7:0] p, input logic [4:0] c);
    logic signed [9:0] d;
    d = $signed({2'b00, p}) - $signed({2'b00, c, 3'b000});
    return (d < 0) ? 9'(-d) : 9'(d);
  endfunction

  always_comb begin
    logic signed [7:0] jx, kx, jh, kq, rv, gv, bv;
    logic bad;
    jx = {{2{chroma_j[5]}}, chroma_j};
    kx = {{2{chroma_k[5]}}, chroma_k};
    jh = jx + (chroma_j[5] ? 8'sd1 : 8'sd0);
    jh = jh >>> 1;
    kq = kx + (chroma_k[5] ? 8'sd3 : 8'sd0);
    kq = kq >>> 2;
    for (int y = 0; y < NumY; y++) begin
      rv = 8'(y) + jx;
      gv = 8'(y) + kx;
      bv = 8'((y * 5) >> 2) - jh - kq;
      bad = (rv < 0) || (rv > 8'sd31) || (gv < 0) || (gv > 8'sd31) ||
            (bv < 0) || (bv > 8'sd31);
      cand_key_next[y] = {bad & ~clamp,
                          10'(absd(red, sat5(rv))) + 10'(absd(green, sat5(gv))) +
                          10'(absd(blue, sat5(bv)))};
    end
  end

  always_comb begin
    for (int g = 0; g < 4; g++) begin
      grp_key_next[g] = cand_key[g * 8];
      grp_y_next[g]   = 5'(g * 8);
      for (int i = 1; i < 8; i++) begin
        if (cand_key[g * 8 + i] < grp_key_next[g]) begin
          grp_key_next[g] = cand_key[g * 8 + i];
          grp_y_next[g]   = 5'(g * 8 + i);
        end
      end
    end
    key_next  = grp_key[0];
    luma_next = grp_y[0];
    for (int g = 1; g < 4; g++) begin
      if (grp_key[g] < key_next) begin
        key_next  = grp_key[g];
        luma_next = grp_y[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    cand_key <= cand_key_next;
    grp_key  <= grp_key_next;
    grp_y    <= grp_y_next;
    key      <= key_next;
    luma     <= luma_next;
  end

endmodule

// File: rtl/core/yjk_group_encoder.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// yjk_group_encoder
// YJK encoder for a group of four RGB pixels; one chroma pair a cycle.
// Flow: a search over all 4096 chroma pairs, a pipeline drain until the pipeline
//   is empty and a clamped final pass on the best pair, then the done strobe.
// A new group is taken only when idle; start is ignored while busy.
// Reset: synchronous; the block comes up idle with no result pending.
// Results cannot be stalled; done is high for one cycle per group.
// ---------------------------------------------------------------------------
module yjk_group_encoder import yjk_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  pixels_t pixels,
  output logic    busy,
  output logic    done,
  output result_t result
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StSrch  = 2'd1;
  localparam logic [1:0] StDrain = 2'd2;
  localparam logic [1:0] StFinal = 2'd3;

  logic [1:0]  state;
  logic [11:0] cnt;
  pixels_t     px;
  logic [SumW-1:0] best_sum;
  logic signed [5:0] bj, bk;

  logic              d_vld   [5];
  logic              d_clamp [5];
  logic signed [5:0] d_j     [5];
  logic signed [5:0] d_k     [5];

  logic [7:0]      pr [NumPix];
  logic [7:0]      pg [NumPix];
  logic [7:0]      pb [NumPix];
  logic [KeyW-1:0] lkey [NumPix];
  logic [4:0]      lluma [NumPix];
  logic [4:0]      ys [NumPix];
  logic [SumW-1:0] sum, sum_next;
  logic            pipe_busy;

  assign busy = (state != StIdle);
  assign pr = '{px.red0, px.red1, px.red2, px.red3};
  assign pg = '{px.green0, px.green1, px.green2, px.green3};
  assign pb = '{px.blue0, px.blue1, px.blue2, px.blue3};

  for (genvar p = 0; p < NumPix; p++) begin : g_lane
    yjk_lane u_lane (
      .clk      (clk),
      .red      (pr[p]),
      .green    (pg[p]),
      .blue     (pb[p]),
      .chroma_j (d_j[0]),
      .chroma_k (d_k[0]),
      .clamp    (d_clamp[0]),
      .key      (lkey[p]),
      .luma     (lluma[p])
    );
  end

  always_comb begin
    sum_next = '0;
    for (int p = 0; p < NumPix; p++) begin
      sum_next = sum_next + (lkey[p][KeyW-1] ? StartErr : SumW'(lkey[p][ErrW-1:0]));
    end
    pipe_busy = 1'b0;
    for (int s = 0; s < 5; s++) pipe_busy = pipe_busy | d_vld[s];
  end

  always_ff @(posedge clk) begin
    for (int s = 1; s < 5; s++) begin
      d_clamp[s] <= d_clamp[s-1];
      d_j[s]     <= d_j[s-1];
      d_k[s]     <= d_k[s-1];
    end
    sum <= sum_next;
    ys  <= lluma;
    result <= '{byte0: {ys[0], d_k[4][2:0]}, byte1: {ys[1], d_k[4][5:3]},
                byte2: {ys[2], d_j[4][2:0]}, byte3: {ys[3], d_j[4][5:3]}};
    if (rst) begin
      state <= StIdle;
      cnt   <= '0;
      done  <= 1'b0;
      for (int s = 0; s < 5; s++) d_vld[s] <= 1'b0;
    end else begin
      for (int s = 1; s < 5; s++) d_vld[s] <= d_vld[s-1];
      d_vld[0] <= (state == StSrch) || ((state == StDrain) && !pipe_busy);
      done <= d_vld[4] & d_clamp[4];
      if ((state == StIdle) && start) begin
        best_sum <= StartErr;
        bj       <= -6'sd32;
        bk       <= -6'sd32;
      end else if (d_vld[4] && !d_clamp[4] && (sum < best_sum)) begin
        best_sum <= sum;
        bj       <= d_j[4];
        bk       <= d_k[4];
      end
      case (state)
        StIdle: begin
          if (start) begin
            px       <= pixels;
            cnt      <= '0;
            state    <= StSrch;
          end
        end
        StSrch: begin
          d_clamp[0] <= 1'b0;
          d_j[0]     <= {~cnt[11], cnt[10:6]};
          d_k[0]     <= {~cnt[5], cnt[4:0]};
          cnt        <= cnt + 12'd1;
          if (cnt == 12'hfff) state <= StDrain;
        end
        StDrain: begin
          if (!pipe_busy) begin
            d_clamp[0] <= 1'b1;
            d_j[0]     <= bj;
            d_k[0]     <= bk;
            state      <= StFinal;
          end
        end
        StFinal: begin
          if (d_vld[4] && d_clamp[4]) state <= StIdle;
        end
        default: state <= StIdle;
      endcase
    end
  end

endmodule
